[src/rgb_to_hsl_converter_macros.svh]
// Assertion helpers for the color converter
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// Check a property on every clock edge outside reset
`define RHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define RHC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/rhc_pkg.sv]
`default_nettype none

package rhc_pkg;

  // Hue sector of the largest channel
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // Hue offsets in 1/64 degree
  localparam logic [14:0] HUE_GREEN_BASE = 15'd7680;
  localparam logic [14:0] HUE_BLUE_BASE  = 15'd15360;
  localparam logic [14:0] HUE_FULL       = 15'd23040;

  // Reciprocal precision: entries hold floor(2^RECIP_SHIFT / n)
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  typedef logic [255:0][RECIP_W-1:0] recip_tab_t;

  // Build the reciprocal table by long division at elaboration
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    logic [RECIP_W:0]   rem;
    logic [RECIP_W-1:0] quo;
    tab = '0;
    for (int n = 1; n < 256; n++) begin
      rem = '0;
      quo = '0;
      for (int b = RECIP_W - 1; b >= 0; b--) begin
        rem = {rem[RECIP_W-1:0], (b == RECIP_SHIFT)};
        if (rem >= (RECIP_W+1)'(n)) begin
          rem    = rem - (RECIP_W+1)'(n);
          quo[b] = 1'b1;
        end
      end
      tab[n] = quo;
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = build_recip();

  // Data carried down the pipeline; each stage fills in its own fields
  typedef struct packed {
    logic [1:0]         sec;
    logic [7:0]         mx;
    logic [7:0]         mn;
    logic signed [8:0]  x;
    logic [7:0]         d;
    logic [8:0]         s;
    logic [7:0]         den;
    logic               neg;
    logic [7:0]         ax;
    logic               grey;
    logic [15:0]        light;
    logic [RECIP_W-1:0] rd;
    logic [RECIP_W-1:0] rden;
    logic [32:0]        ph;
    logic [32:0]        ps;
    logic [11:0]        qh;
    logic [16:0]        qs;
    logic [19:0]        mh;
    logic [24:0]        ms;
    logic [11:0]        qhf;
    logic               nz;
    logic [16:0]        qsf;
    logic [14:0]        hue;
    logic [15:0]        sat;
  } pipe_t;

endpackage

`default_nettype wire

[src/rgb_to_hsl_converter.sv]
// Throughput: one item per cycle while the output is not stalled, through an
// eight-stage pipeline with a reciprocal-multiply divider (table lookup, multiply,
// back-multiply, one-step correction).
// Each stage holds its item while the stage after it is full and stalled.
// Reset (rst, synchronous, active high) clears every stage valid bit; data
// registers keep their contents.
`default_nettype none

`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // hue[14:0], saturation[30:15],
                                      // lightness[46:31], zero[47]
);
  import rhc_pkg::*;

  localparam int NSTG = 8;

  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  pipe_t st1, st2, st3, st4, st5, st6, st7, st8;
  pipe_t st1_next, st2_next, st3_next, st4_next;
  pipe_t st5_next, st6_next, st7_next, st8_next;

  logic [7:0]  red, green, blue;
  logic [19:0] nh, rem_h, rem_h2;
  logic [24:0] rem_s;
  logic        corr_h, corr_s;
  logic [11:0] ch;
  logic [14:0] base;

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  // Advance a stage when it is empty or the next one takes its item
  always_comb begin
    en[NSTG] = !vld[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  // Move valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: find max, min, sector and the hue numerator
  always_comb begin
    st1_next = '0;
    st1_next.mx = red;
    st1_next.mn = red;
    if (green > st1_next.mx) st1_next.mx = green;
    if (blue  > st1_next.mx) st1_next.mx = blue;
    if (green < st1_next.mn) st1_next.mn = green;
    if (blue  < st1_next.mn) st1_next.mn = blue;
    if (red >= green && red >= blue) begin
      st1_next.sec = SEC_RED;
      st1_next.x   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      st1_next.sec = SEC_GREEN;
      st1_next.x   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      st1_next.sec = SEC_BLUE;
      st1_next.x   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  // Stage 2: delta, sum, saturation divisor, lightness
  always_comb begin
    st2_next       = st1;
    st2_next.d     = st1.mx - st1.mn;
    st2_next.s     = {1'b0, st1.mx} + {1'b0, st1.mn};
    st2_next.grey  = (st1.mx == st1.mn);
    st2_next.neg   = st1.x[8];
    st2_next.ax    = st1.x[8] ? 8'(-st1.x) : st1.x[7:0];
    if (st2_next.s < 9'd255) st2_next.den = st2_next.s[7:0];
    else                     st2_next.den = 8'(9'd510 - st2_next.s);
    // 65535*s/510 = 128*s + floor(s/2)
    st2_next.light = {st2_next.s, 7'd0} + {8'd0, st2_next.s[8:1]};
  end

  // Stage 3: look up reciprocals
  always_comb begin
    st3_next      = st2;
    st3_next.rd   = RECIP[st2.d];
    st3_next.rden = RECIP[st2.den];
  end

  // Stage 4: scale numerators by the reciprocals
  always_comb begin
    st4_next    = st3;
    st4_next.ph = {25'd0, st3.ax} * {8'd0, st3.rd};
    st4_next.ps = {25'd0, st3.d}  * {8'd0, st3.rden};
  end

  // Stage 5: estimate quotients (hue numerator carries the factor 3840)
  logic [36:0] ph15;
  always_comb begin
    st5_next = st4;
    ph15     = {st4.ph, 4'd0} - {4'd0, st4.ph};
    st5_next.qh = ph15[27:16];
    st5_next.qs = st4.ps[24:8];
  end

  // Stage 6: multiply estimates back by the divisors
  always_comb begin
    st6_next    = st5;
    st6_next.mh = {8'd0, st5.qh} * {12'd0, st5.d};
    st6_next.ms = {8'd0, st5.qs} * {17'd0, st5.den};
  end

  // Stage 7: correct each estimate by one where the remainder is too large
  always_comb begin
    st7_next = st6;
    nh       = {st6.ax, 12'd0} - {4'd0, st6.ax, 8'd0};
    rem_h    = nh - st6.mh;
    corr_h   = (rem_h >= {12'd0, st6.d});
    rem_h2   = corr_h ? rem_h - {12'd0, st6.d} : rem_h;
    st7_next.qhf = st6.qh + 12'(corr_h);
    st7_next.nz  = (rem_h2 != 20'd0);
    rem_s    = {1'b0, st6.d, 16'd0} - st6.ms;
    corr_s   = (rem_s >= {17'd0, st6.den});
    st7_next.qsf = st6.qs + 17'(corr_s);
  end

  // Stage 8: place hue in its sector, saturate saturation
  always_comb begin
    st8_next = st7;
    ch       = st7.qhf + 12'(st7.nz);
    case (st7.sec)
      SEC_RED:   base = st7.neg ? HUE_FULL : 15'd0;
      SEC_GREEN: base = HUE_GREEN_BASE;
      SEC_BLUE:  base = HUE_BLUE_BASE;
      default:   base = 15'd0;
    endcase
    if (st7.grey) begin
      st8_next.hue = 15'd0;
      st8_next.sat = 16'd0;
    end else begin
      st8_next.hue = st7.neg ? base - {3'd0, ch} : base + {3'd0, st7.qhf};
      st8_next.sat = st7.qsf[16] ? 16'hFFFF : st7.qsf[15:0];
    end
  end

  // Hold each stage while it is stalled
  always_ff @(posedge clk) begin
    if (en[1]) st1 <= st1_next;
    if (en[2]) st2 <= st2_next;
    if (en[3]) st3 <= st3_next;
    if (en[4]) st4 <= st4_next;
    if (en[5]) st5 <= st5_next;
    if (en[6]) st6 <= st6_next;
    if (en[7]) st7 <= st7_next;
    if (en[8]) st8 <= st8_next;
  end

  assign m_axis_tvalid = vld[NSTG];
  assign m_axis_tdata  = {1'b0, st8.light, st8.sat, st8.hue};

  `RHC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid right after reset")
  `RHC_ASSERT(a_hue_range, m_axis_tvalid |-> (st8.hue < HUE_FULL), "hue out of range")
  `RHC_ASSERT(a_grey_hue, (m_axis_tvalid && st8.sat == 16'd0) |-> (st8.hue == 15'd0), "zero saturation with nonzero hue")
  `RHC_ASSERT(a_est_close, (vld[6] && !st6.grey) |-> (rem_h < {11'd0, st6.d, 1'b0}), "hue quotient estimate off by more than one")

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  import rhc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PIXELS = 1800;
  localparam int HUE_SIXTY = 3840;  // 60 degrees in 1/64 degree units
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_START = 600;
  localparam int HOLD_CYCLES = 400;

  // One expected result; packed in reverse output order, lowest field first
  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [15:0] light;
  } hsl_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         known;
    hsl_t       want;
  } pixel_row_t;

  localparam int NUM_ROWS = 21;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // hue[14:0], saturation[30:15],
                                    // lightness[46:31], zero[47]

  hsl_t        pending_hsl[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  pixel_row_t  dir_rows [NUM_ROWS];

  rgb_to_hsl_converter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Reset, held high from the start and then released
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Cycle counter and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Division rounded toward minus infinity
  function automatic int floor_div(input int num, input int den);
    int q;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    return q;
  endfunction

  // Expected hue, saturation and lightness of one pixel
  function automatic hsl_t hsl_of(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    int   rr, gg, bb, mx, mn, d, s, den, sat, h;
    hsl_t res;
    rr = int'(r);
    gg = int'(g);
    bb = int'(b);
    mx = rr;
    mn = rr;
    if (gg > mx) mx = gg;
    if (bb > mx) mx = bb;
    if (gg < mn) mn = gg;
    if (bb < mn) mn = bb;
    d = mx - mn;
    s = mx + mn;
    sat = 0;
    h = 0;
    if (d != 0) begin
      den = (s < 255) ? s : 510 - s;
      sat = (d * 65536) / den;
      if (sat > 65535) sat = 65535;
      // red wins ties, then green
      if (rr >= gg && rr >= bb) begin
        h = floor_div(HUE_SIXTY * (gg - bb), d);
        if (h < 0) h = h + int'(HUE_FULL);
      end else if (gg >= rr && gg >= bb) begin
        h = int'(HUE_GREEN_BASE) + floor_div(HUE_SIXTY * (bb - rr), d);
      end else begin
        h = int'(HUE_BLUE_BASE) + floor_div(HUE_SIXTY * (rr - gg), d);
      end
    end
    res.hue = 15'(h);
    res.sat = 16'(sat);
    res.light = 16'((s * 65535) / 510);
    return res;
  endfunction

  // Random idle length: mostly short, a few long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one pixel, record its expected result once accepted, then idle
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input bit steady,
                            input bit known, input hsl_t want);
    int gap;
    s_axis_tdata <= {b, g, r};
    if (!s_axis_tvalid) s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_hsl.push_back(known ? want : hsl_of(r, g, b));
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, steady windows, and one long hold-off
  initial begin
    int  high;
    int  gap;
    bit  held;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && cycle_count >= HOLD_START) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      high = $urandom_range(1, 16);
      repeat (high) @(posedge clk);
      gap = ((cycle_count / 512) % 4 == 2) ? 0 : idle_len();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Compare each delivered item with the oldest expectation
  always @(posedge clk) begin
    hsl_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_hsl.size() == 0) begin
        $error("unexpected item: tdata=%h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_hsl.pop_front();
        if (m_axis_tdata[14:0] !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, m_axis_tdata[14:0]);
          fail_count++;
        end
        if (m_axis_tdata[30:15] !== want.sat) begin
          $error("saturation: expected %0d, got %0d", want.sat, m_axis_tdata[30:15]);
          fail_count++;
        end
        if (m_axis_tdata[46:31] !== want.light) begin
          $error("lightness: expected %0d, got %0d", want.light, m_axis_tdata[46:31]);
          fail_count++;
        end
        if (m_axis_tdata[47] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_axis_tdata[47]);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: directed rows, then random pixels
  initial begin
    logic [7:0] va, vb, vc, pr, pg, pb;
    int         sel, rot;

    // known rows carry the result as read off the definition directly
    dir_rows = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, {15'd0,     16'd0,     16'd0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, {15'd0,     16'd0,     16'd65535}},
      '{8'd255, 8'd0,   8'd0,   1'b1, {15'd0,     16'd65535, 16'd32767}},
      '{8'd0,   8'd255, 8'd0,   1'b1, {15'd7680,  16'd65535, 16'd32767}},
      '{8'd0,   8'd0,   8'd255, 1'b1, {15'd15360, 16'd65535, 16'd32767}},
      '{8'd1,   8'd0,   8'd0,   1'b1, {15'd0,     16'd65535, 16'd128}},
      // red and green tie, green and blue tie, red and blue tie
      '{8'd255, 8'd255, 8'd0,   1'b0, '0},
      '{8'd0,   8'd255, 8'd255, 1'b0, '0},
      '{8'd255, 8'd0,   8'd255, 1'b0, '0},
      '{8'd0,   8'd1,   8'd0,   1'b0, '0},
      '{8'd0,   8'd0,   8'd1,   1'b0, '0},
      // red sector going negative, wrapped by a full turn
      '{8'd255, 8'd0,   8'd1,   1'b0, '0},
      '{8'd128, 8'd128, 8'd128, 1'b0, '0},
      '{8'd170, 8'd85,  8'd170, 1'b0, '0},
      '{8'd85,  8'd170, 8'd85,  1'b0, '0},
      // around lightness one half
      '{8'd254, 8'd0,   8'd0,   1'b0, '0},
      '{8'd200, 8'd55,  8'd55,  1'b0, '0},
      '{8'd201, 8'd55,  8'd55,  1'b0, '0},
      '{8'd255, 8'd254, 8'd254, 1'b0, '0},
      '{8'd10,  8'd200, 8'd100, 1'b0, '0},
      '{8'd90,  8'd20,  8'd240, 1'b0, '0}
    };

    do @(posedge clk); while (rst);

    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, 1'b0,
                 dir_rows[i].known, dir_rows[i].want);
    end

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      sel = $urandom_range(0, 9);
      va = 8'($urandom);
      vb = 8'($urandom);
      vc = 8'($urandom);
      case (sel)
        0: begin
          // grey
          vb = va;
          vc = va;
        end
        1: begin
          // two channels tie for the maximum
          va = 8'($urandom_range(1, 255));
          vb = va;
          vc = 8'($urandom_range(0, int'(va) - 1));
        end
        2: begin
          va = 8'($urandom_range(0, 1)) | {8{$urandom_range(0, 1) == 1}};
          vb = 8'($urandom_range(0, 1)) | {8{$urandom_range(0, 1) == 1}};
          vc = 8'($urandom_range(0, 1)) | {8{$urandom_range(0, 1) == 1}};
          va = ($urandom_range(0, 1) == 1) ? va ^ 8'd1 : va;
        end
        3: begin
          // dark, nearly or fully saturated
          va = 8'($urandom_range(0, 3));
          vb = 8'($urandom_range(0, 3));
          vc = 8'($urandom_range(0, 3));
        end
        4: begin
          // max + min close to 255
          va = 8'($urandom_range(128, 255));
          vb = 8'(255 - int'(va) + $urandom_range(0, 1));
          vc = 8'($urandom_range(int'(vb), int'(va)));
        end
        default: ;
      endcase
      rot = $urandom_range(0, 2);
      case (rot)
        0: {pr, pg, pb} = {va, vb, vc};
        1: {pr, pg, pb} = {vb, vc, va};
        default: {pr, pg, pb} = {vc, va, vb};
      endcase
      send_pixel(pr, pg, pb, (i % 400) < 80, 1'b0, '0);
    end

    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;

    // Drain outstanding results
    while (pending_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/rhc_pkg.sv
src/rgb_to_hsl_converter.sv
test/tb_top.sv
